[hw/rtl/segment_line_hit_point_macros.svh]
// ---------------------------------------------------------------------------
// segment_line_hit_point assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_LINE_HIT_POINT_MACROS_SVH
`define SEGMENT_LINE_HIT_POINT_MACROS_SVH

// same-cycle implication
`define SLHP_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLHP_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/slhp_pkg.sv]
// ---------------------------------------------------------------------------
// slhp_pkg
// Widths, types and constants of the segment/line hit point pipeline.
// ---------------------------------------------------------------------------
package slhp_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int REM_BITS   = CROSS_BITS + 1;
    localparam int Q_BITS     = T_FRAC_BITS + 1;
    localparam int PT_BITS    = Q_BITS + 1 + DIFF_BITS;
    localparam int DIV_STAGES = T_FRAC_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;
    typedef logic        [CROSS_BITS-1:0] mag_t;
    typedef logic        [REM_BITS-1:0]   rem_t;
    typedef logic        [Q_BITS-1:0]     quo_t;
    typedef logic signed [PT_BITS-1:0]    scaled_t;

    localparam scaled_t ROUND_HALF = scaled_t'(1) <<< (T_FRAC_BITS - 1);

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
        coord_t line_a_x;
        coord_t line_a_y;
        coord_t line_b_x;
        coord_t line_b_y;
    } query_t;

    // per-item context carried alongside the divider
    typedef struct packed {
        logic   ok;
        coord_t x1;
        coord_t y1;
        coord_t xb;
        coord_t yb;
        diff_t  d21x;
        diff_t  d21y;
        diff_t  dabx;
        diff_t  daby;
    } pt_ctx_t;

    typedef struct packed {
        pt_ctx_t ctx;
        mag_t    num;
        mag_t    den;
    } div_req_t;

    typedef struct packed {
        pt_ctx_t ctx;
        quo_t    t;
    } div_rsp_t;

    typedef struct packed {
        coord_t hit_x;
        coord_t hit_y;
        logic   hit_found;
    } hit_result_t;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

endpackage

[hw/rtl/slhp_query_if.sv]
// ---------------------------------------------------------------------------
// slhp_query_if
// Input channel: segment and line endpoints, valid/ready.
// ---------------------------------------------------------------------------
interface slhp_query_if;
    import slhp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t line_a_x;
    coord_t line_a_y;
    coord_t line_b_x;
    coord_t line_b_y;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        output line_a_x, line_a_y, line_b_x, line_b_y,
        input  ready
    );

    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
        input  line_a_x, line_a_y, line_b_x, line_b_y,
        output ready
    );
endinterface

[hw/rtl/slhp_hit_if.sv]
// ---------------------------------------------------------------------------
// slhp_hit_if
// Result channel: hit point and hit flag, valid/ready.
// ---------------------------------------------------------------------------
interface slhp_hit_if;
    import slhp_pkg::*;

    logic   valid;
    logic   ready;
    coord_t hit_x;
    coord_t hit_y;
    logic   hit_found;

    modport source (
        output valid, hit_x, hit_y, hit_found,
        input  ready
    );

    modport sink (
        input  valid, hit_x, hit_y, hit_found,
        output ready
    );
endinterface

[hw/rtl/slhp_cross.sv]
// ---------------------------------------------------------------------------
// slhp_cross
// Four stages: differences, products, cross terms, sign test and magnitudes.
// ---------------------------------------------------------------------------
module slhp_cross (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  slhp_pkg::query_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output slhp_pkg::div_req_t out_data
);
    import slhp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    pt_ctx_t ctx1_reg, ctx1_next;
    diff_t   d12x_reg, d12y_reg, d1ax_reg, d1ay_reg;
    diff_t   d12x_next, d12y_next, d1ax_next, d1ay_next;

    pt_ctx_t ctx2_reg;
    prod_t   p0_reg, p1_reg, p2_reg, p3_reg;
    prod_t   p0_next, p1_next, p2_next, p3_next;

    pt_ctx_t ctx3_reg;
    cross_t  m_reg, l_reg, m_next, l_next;

    div_req_t req_reg, req_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: coordinate differences
    always_comb
    begin
        ctx1_next.ok   = 1'b0;
        ctx1_next.x1   = in_data.seg_start_x;
        ctx1_next.y1   = in_data.seg_start_y;
        ctx1_next.xb   = in_data.line_b_x;
        ctx1_next.yb   = in_data.line_b_y;
        ctx1_next.d21x = sub_ext(in_data.seg_end_x, in_data.seg_start_x);
        ctx1_next.d21y = sub_ext(in_data.seg_end_y, in_data.seg_start_y);
        ctx1_next.dabx = sub_ext(in_data.line_a_x, in_data.line_b_x);
        ctx1_next.daby = sub_ext(in_data.line_a_y, in_data.line_b_y);
        d12x_next = sub_ext(in_data.seg_start_x, in_data.seg_end_x);
        d12y_next = sub_ext(in_data.seg_start_y, in_data.seg_end_y);
        d1ax_next = sub_ext(in_data.seg_start_x, in_data.line_a_x);
        d1ay_next = sub_ext(in_data.seg_start_y, in_data.line_a_y);
    end

    // stage 2: products
    always_comb
    begin
        p0_next = d12x_reg * ctx1_reg.daby;
        p1_next = d12y_reg * ctx1_reg.dabx;
        p2_next = d1ax_reg * ctx1_reg.daby;
        p3_next = d1ay_reg * ctx1_reg.dabx;
    end

    // stage 3: denominator and numerator
    always_comb
    begin
        m_next = cross_t'(p0_reg) - cross_t'(p1_reg);
        l_next = cross_t'(p2_reg) - cross_t'(p3_reg);
    end

    // stage 4: t >= 0 test and magnitudes
    always_comb
    begin
        logic m_zero;
        logic l_zero;
        logic opposite;
        m_zero   = (m_reg == '0);
        l_zero   = (l_reg == '0);
        opposite = (m_reg[CROSS_BITS-1] != l_reg[CROSS_BITS-1]) && !m_zero && !l_zero;
        req_next.ctx    = ctx3_reg;
        req_next.ctx.ok = !m_zero && !opposite;
        req_next.den    = m_reg[CROSS_BITS-1] ? mag_t'(-m_reg) : mag_t'(m_reg);
        req_next.num    = l_reg[CROSS_BITS-1] ? mag_t'(-l_reg) : mag_t'(l_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ctx1_reg <= ctx1_next;
            d12x_reg <= d12x_next;
            d12y_reg <= d12y_next;
            d1ax_reg <= d1ax_next;
            d1ay_reg <= d1ay_next;
        end
        if (rdy2)
        begin
            ctx2_reg <= ctx1_reg;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
        end
        if (rdy3)
        begin
            ctx3_reg <= ctx2_reg;
            m_reg    <= m_next;
            l_reg    <= l_next;
        end
        if (rdy4)
        begin
            req_reg <= req_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = req_reg;

endmodule

[hw/rtl/slhp_div.sv]
// ---------------------------------------------------------------------------
// slhp_div
// Pipelined restoring divider: one quotient bit per stage, t = |L|*2^T/|M|.
// ---------------------------------------------------------------------------
module slhp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  slhp_pkg::div_req_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output slhp_pkg::div_rsp_t out_data
);
    import slhp_pkg::*;

    logic                  vld_reg [DIV_STAGES];
    logic                  rdy     [DIV_STAGES+1];
    pt_ctx_t               ctx_reg [DIV_STAGES];
    mag_t                  den_reg [DIV_STAGES];
    rem_t                  rem_reg [DIV_STAGES];
    quo_t                  quo_reg [DIV_STAGES];

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic    vld_in;
        pt_ctx_t ctx_next;
        mag_t    den_next;
        rem_t    rem_in;
        quo_t    quo_in;
        rem_t    rem_next;
        quo_t    quo_next;
        logic    take;

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                vld_in      = in_valid;
                ctx_next    = in_data.ctx;
                ctx_next.ok = in_data.ctx.ok && (in_data.num <= in_data.den);
                den_next    = in_data.den;
                rem_in      = rem_t'(in_data.num);
                quo_in      = '0;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vld_in   = vld_reg[k-1];
                ctx_next = ctx_reg[k-1];
                den_next = den_reg[k-1];
                rem_in   = rem_reg[k-1] << 1;
                quo_in   = quo_reg[k-1];
            end
        end

        always_comb
        begin
            take     = (rem_in >= rem_t'(den_next));
            rem_next = take ? (rem_in - rem_t'(den_next)) : rem_in;
            quo_next = {quo_in[Q_BITS-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                ctx_reg[k] <= ctx_next;
                den_reg[k] <= den_next;
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign out_valid    = vld_reg[DIV_STAGES-1];
    assign out_data.ctx = ctx_reg[DIV_STAGES-1];
    assign out_data.t   = quo_reg[DIV_STAGES-1];

endmodule

[hw/rtl/slhp_point.sv]
// ---------------------------------------------------------------------------
// slhp_point
// Five stages: scale, round, offset to B, dot terms, sign test and result.
// ---------------------------------------------------------------------------
module slhp_point (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slhp_pkg::div_rsp_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output slhp_pkg::hit_result_t out_data
);
    import slhp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    pt_ctx_t ctx1_reg;
    scaled_t sx_reg, sy_reg, sx_next, sy_next;

    pt_ctx_t ctx2_reg;
    coord_t  hx2_reg, hy2_reg, hx_next, hy_next;

    logic    ok3_reg, ok4_reg;
    diff_t   dabx3_reg, daby3_reg;
    coord_t  hx3_reg, hy3_reg, hx4_reg, hy4_reg;
    diff_t   ex_reg, ey_reg, ex_next, ey_next;
    prod_t   px_reg, py_reg, px_next, py_next;

    hit_result_t res_reg, res_next;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // t * (P2 - P1), T_FRAC_BITS fraction bits
    always_comb
    begin
        sx_next = $signed({1'b0, in_data.t}) * in_data.ctx.d21x;
        sy_next = $signed({1'b0, in_data.t}) * in_data.ctx.d21y;
    end

    // round half up, add P1; for a t within 0..1 the result stays between P1 and P2
    always_comb
    begin
        scaled_t rx;
        scaled_t ry;
        rx      = (sx_reg + ROUND_HALF) >>> T_FRAC_BITS;
        ry      = (sy_reg + ROUND_HALF) >>> T_FRAC_BITS;
        hx_next = ctx1_reg.x1 + coord_t'(rx[COORD_BITS-1:0]);
        hy_next = ctx1_reg.y1 + coord_t'(ry[COORD_BITS-1:0]);
    end

    always_comb
    begin
        ex_next = sub_ext(hx2_reg, ctx2_reg.xb);
        ey_next = sub_ext(hy2_reg, ctx2_reg.yb);
    end

    always_comb
    begin
        px_next = dabx3_reg * ex_reg;
        py_next = daby3_reg * ey_reg;
    end

    always_comb
    begin
        cross_t dot;
        dot                = cross_t'(px_reg) + cross_t'(py_reg);
        res_next.hit_found = ok4_reg && (dot > 0);
        res_next.hit_x     = res_next.hit_found ? hx4_reg : '0;
        res_next.hit_y     = res_next.hit_found ? hy4_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ctx1_reg <= in_data.ctx;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
        end
        if (rdy2)
        begin
            ctx2_reg <= ctx1_reg;
            hx2_reg  <= hx_next;
            hy2_reg  <= hy_next;
        end
        if (rdy3)
        begin
            ok3_reg   <= ctx2_reg.ok;
            dabx3_reg <= ctx2_reg.dabx;
            daby3_reg <= ctx2_reg.daby;
            hx3_reg   <= hx2_reg;
            hy3_reg   <= hy2_reg;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
        end
        if (rdy4)
        begin
            ok4_reg <= ok3_reg;
            hx4_reg <= hx3_reg;
            hy4_reg <= hy3_reg;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
        if (rdy5)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = res_reg;

endmodule

[hw/rtl/segment_line_hit_point.sv]
// ---------------------------------------------------------------------------
// segment_line_hit_point
// Intersection of a segment with a line, kept only on the side of B toward A.
//
// Channels: query (sink) takes one beat per test: segment P1-P2 and line
// points A, B, all signed Q12.4. hit (source) returns exactly one beat per
// query, in order: hit_x, hit_y (Q12.4, zero on a miss) and hit_found.
// Pipeline: T_FRAC_BITS + 10 register stages from the query beat to its
// hit beat. Four stages form the cross products, one stage per quotient bit
// of t does the restoring divide, five stages scale, round and run the
// dot-product test.
// Throughput: one beat per cycle sustained while hit.ready is held high.
// Reset: all stage valid bits clear; the pipeline is empty and query.ready
// is high.
// Stall: each stage holds while the stage after it is full and stalled, so
// a stalled hit beat fills the pipeline back to the input; query.ready
// drops only once every stage holds a beat. Nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module segment_line_hit_point (
    input  logic   clk,
    input  logic   rst_n,
    slhp_query_if.sink query,
    slhp_hit_if.source hit
);
    import slhp_pkg::*;

    query_t      q_data;
    logic        req_valid, req_ready;
    div_req_t    req_data;
    logic        rsp_valid, rsp_ready;
    div_rsp_t    rsp_data;
    hit_result_t res_data;

    always_comb
    begin
        q_data.seg_start_x = query.seg_start_x;
        q_data.seg_start_y = query.seg_start_y;
        q_data.seg_end_x   = query.seg_end_x;
        q_data.seg_end_y   = query.seg_end_y;
        q_data.line_a_x    = query.line_a_x;
        q_data.line_a_y    = query.line_a_y;
        q_data.line_b_x    = query.line_b_x;
        q_data.line_b_y    = query.line_b_y;
    end

    slhp_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .in_data   (q_data),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .out_data  (req_data)
    );

    slhp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req_data),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp_data)
    );

    slhp_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rsp_valid),
        .in_ready  (rsp_ready),
        .in_data   (rsp_data),
        .out_valid (hit.valid),
        .out_ready (hit.ready),
        .out_data  (res_data)
    );

    assign hit.hit_x     = res_data.hit_x;
    assign hit.hit_y     = res_data.hit_y;
    assign hit.hit_found = res_data.hit_found;

endmodule

[hw/rtl/slhp_checker.sv]
// ---------------------------------------------------------------------------
// slhp_checker
// Port-level checks on the hit pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`include "segment_line_hit_point_macros.svh"

module slhp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input slhp_pkg::coord_t     hit_x,
    input slhp_pkg::coord_t     hit_y,
    input logic                 hit_found
);
    import slhp_pkg::*;

    // a miss carries a zero point
    `SLHP_ASSERT_NOW(a_miss_zero, out_valid && !hit_found, (hit_x == '0) && (hit_y == '0), "miss beat with nonzero point")

    // output stage free or draining: every stage can advance, input open
    `SLHP_ASSERT_NOW(a_in_open, !out_valid || out_ready, in_ready, "input blocked while pipeline can advance")

    // stalled result beat holds
    `SLHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit_x) && $stable(hit_y) && $stable(hit_found), "stalled hit beat changed")

    // stalled query beat stays offered
    `SLHP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid, "query beat withdrawn while stalled")

endmodule

bind segment_line_hit_point slhp_checker u_slhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (hit.valid),
    .out_ready (hit.ready),
    .hit_x     (hit.hit_x),
    .hit_y     (hit.hit_y),
    .hit_found (hit.hit_found)
);

[tb/hit_point_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hit_point_checker
// Watches the query and hit channels of segment_line_hit_point. Each query
// beat gets its expected hit point computed here; each hit beat is compared
// field by field, in order, against the oldest expected hit point.
// ---------------------------------------------------------------------------
module hit_point_checker (
    input  logic       clk,
    input  logic       rst_n,
    slhp_query_if      query,
    slhp_hit_if        hit,
    output int         mismatches,
    output int         outstanding,
    output int         results_seen,
    output int         hits_seen
);
    import slhp_pkg::*;

    hit_result_t expected_hits[$];
    query_t      seen_query;

    assign seen_query = {query.seg_start_x, query.seg_start_y, query.seg_end_x,
                         query.seg_end_y, query.line_a_x, query.line_a_y,
                         query.line_b_x, query.line_b_y};

    // exact integer cross products; t = floor(|L| * 2^T / |M|)
    function automatic hit_result_t compute_hit_point(query_t qv);
        longint      x1, y1, x2, y2, xa, ya, xb, yb;
        longint      den, num, aden, anum, t, hx, hy, dot;
        hit_result_t res;
        res = '0;
        x1  = longint'(qv.seg_start_x);
        y1  = longint'(qv.seg_start_y);
        x2  = longint'(qv.seg_end_x);
        y2  = longint'(qv.seg_end_y);
        xa  = longint'(qv.line_a_x);
        ya  = longint'(qv.line_a_y);
        xb  = longint'(qv.line_b_x);
        yb  = longint'(qv.line_b_y);
        den = (x1 - x2) * (ya - yb) - (y1 - y2) * (xa - xb);
        num = (x1 - xa) * (ya - yb) - (y1 - ya) * (xa - xb);
        if (den == 0 || (den > 0 && num < 0) || (den < 0 && num > 0))
            return res;
        aden = (den < 0) ? -den : den;
        anum = (num < 0) ? -num : num;
        if (anum > aden)
            return res;
        t  = (anum <<< T_FRAC_BITS) / aden;
        hx = x1 + ((t * (x2 - x1) + (longint'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS);
        hy = y1 + ((t * (y2 - y1) + (longint'(1) <<< (T_FRAC_BITS - 1))) >>> T_FRAC_BITS);
        dot = (xa - xb) * (hx - xb) + (ya - yb) * (hy - yb);
        if (dot <= 0)
            return res;
        res.hit_x     = coord_t'(hx);
        res.hit_y     = coord_t'(hy);
        res.hit_found = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t want;
        if (!rst_n)
        begin
            expected_hits.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
            hits_seen    = 0;
        end
        else
        begin
            if (query.valid && query.ready)
                expected_hits.push_back(compute_hit_point(seen_query));
            if (hit.valid && hit.ready)
            begin
                results_seen++;
                if (hit.hit_found)
                    hits_seen++;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected hit beat: expected none, got x=%0d y=%0d found=%0b",
                             $time, hit.hit_x, hit.hit_y, hit.hit_found);
                    mismatches++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit.hit_x !== want.hit_x)
                    begin
                        $display("%0t: hit_x mismatch: expected %0d, got %0d",
                                 $time, want.hit_x, hit.hit_x);
                        mismatches++;
                    end
                    if (hit.hit_y !== want.hit_y)
                    begin
                        $display("%0t: hit_y mismatch: expected %0d, got %0d",
                                 $time, want.hit_y, hit.hit_y);
                        mismatches++;
                    end
                    if (hit.hit_found !== want.hit_found)
                    begin
                        $display("%0t: hit_found mismatch: expected %0b, got %0b",
                                 $time, want.hit_found, hit.hit_found);
                        mismatches++;
                    end
                end
            end
            outstanding = expected_hits.size();
        end
    end
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives segment/line queries into segment_line_hit_point: a directed set of
// corner geometries, then random queries under three pacing phases. The
// checker beside the block predicts and compares every hit beat.
// ---------------------------------------------------------------------------
module testbench;
    import slhp_pkg::*;

    localparam int RANDOM_PER_PHASE = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int STALL_LIMIT      = 4000;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   stall_cycles;
    int   mismatches;
    int   outstanding;
    int   results_seen;
    int   hits_seen;

    slhp_query_if query_ch ();
    slhp_hit_if   hit_ch ();

    segment_line_hit_point i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .query (query_ch),
        .hit   (hit_ch)
    );

    hit_point_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .query        (query_ch),
        .hit          (hit_ch),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    // 1.0 is 16 in Q12.4
    query_t corner_queries [18] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 256, 0, 0, 256, 256, 256},
        '{0, -512, 0, 512, 512, 0, -512, 0},
        '{0, 512, 0, -512, 512, 0, -512, 0},
        '{0, -512, 0, 512, -1024, 0, -512, 0},
        '{0, -512, 0, 512, 512, 0, 0, 0},
        '{0, 0, 0, 512, 512, 0, -512, 0},
        '{0, -512, 0, 0, 512, 0, -512, 0},
        '{0, 256, 0, 512, 512, 0, -512, 0},
        '{0, -1, 5, 2, 1600, 0, -1600, 0},
        '{-3, -7, 9, 11, 1000, 1, -1000, -2},
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
        '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767},
        '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
        '{-32768, 32767, 32767, -32768, -1, 0, 0, -1},
        '{0, -512, 512, 512, 0, 0, 1, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic coord_t near_coord();
        return coord_t'(int'($urandom_range(0, 255)) - 128);
    endfunction

    function automatic query_t random_query();
        query_t qv;
        int     kind;
        int     dx;
        int     dy;
        kind = $urandom_range(0, 99);
        qv   = query_t'({$urandom, $urandom, $urandom, $urandom});
        if (kind < 50)
        begin
            qv.seg_start_x = near_coord();
            qv.seg_start_y = near_coord();
            qv.seg_end_x   = near_coord();
            qv.seg_end_y   = near_coord();
            qv.line_a_x    = near_coord();
            qv.line_a_y    = near_coord();
            qv.line_b_x    = near_coord();
            qv.line_b_y    = near_coord();
            if (kind < 8)
            begin
                // parallel or collinear
                dx = int'($urandom_range(0, 31)) - 16;
                dy = int'($urandom_range(0, 31)) - 16;
                qv.seg_end_x = qv.seg_start_x + coord_t'(2 * dx);
                qv.seg_end_y = qv.seg_start_y + coord_t'(2 * dy);
                qv.line_b_x  = qv.line_a_x + coord_t'(3 * dx);
                qv.line_b_y  = qv.line_a_y + coord_t'(3 * dy);
            end
            else if (kind < 13)
            begin
                qv.seg_start_x = qv.line_a_x;
                qv.seg_start_y = qv.line_a_y;
            end
            else if (kind < 18)
            begin
                qv.seg_end_x = qv.line_b_x;
                qv.seg_end_y = qv.line_b_y;
            end
        end
        return qv;
    endfunction

    task automatic send_query(input query_t qv);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(negedge clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.seg_start_x <= qv.seg_start_x;
        query_ch.seg_start_y <= qv.seg_start_y;
        query_ch.seg_end_x   <= qv.seg_end_x;
        query_ch.seg_end_y   <= qv.seg_end_y;
        query_ch.line_a_x    <= qv.line_a_x;
        query_ch.line_a_y    <= qv.line_a_y;
        query_ch.line_b_x    <= qv.line_b_x;
        query_ch.line_b_y    <= qv.line_b_y;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        hit_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hit_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((query_ch.valid && query_ch.ready) || (hit_ch.valid && hit_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int n;
        int phase;
        rst_n                = 1'b0;
        src_idle_pct         = 27;
        sink_idle_pct        = 83;
        query_ch.valid       = 1'b0;
        query_ch.seg_start_x = '0;
        query_ch.seg_start_y = '0;
        query_ch.seg_end_x   = '0;
        query_ch.seg_end_y   = '0;
        query_ch.line_a_x    = '0;
        query_ch.line_a_y    = '0;
        query_ch.line_b_x    = '0;
        query_ch.line_b_y    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_queries[i])
            send_query(corner_queries[i]);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 83;
                end
                1:
                begin
                    src_idle_pct  = 83;
                    sink_idle_pct = 27;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_query(random_query());
        end
        query_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d hit beats: %0d hits, %0d misses.",
                 results_seen, hits_seen, results_seen - hits_seen);
        $display("Corner geometries plus random queries under three pacing phases.");
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[segment_line_hit_point.f]
+incdir+hw/rtl
hw/rtl/slhp_pkg.sv
hw/rtl/slhp_query_if.sv
hw/rtl/slhp_hit_if.sv
hw/rtl/slhp_cross.sv
hw/rtl/slhp_div.sv
hw/rtl/slhp_point.sv
hw/rtl/segment_line_hit_point.sv
hw/rtl/slhp_checker.sv
tb/hit_point_checker.sv
tb/testbench.sv
